// File: src/hsv_hsl_to_rgb565_unit_macros.svh
// Assertion macros for the HSV/HSL to RGB565 unit.
// Used by the port checker; expects clk_i and rst_ni in the calling scope.
`ifndef HSV_HSL_TO_RGB565_UNIT_MACROS_SVH
`define HSV_HSL_TO_RGB565_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HHR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hhr assertion failed");

// Next-cycle implication, disabled during reset
`define HHR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hhr assertion failed");

`endif

// File: src/hhr_pkg.sv
// Shared types and constants for the HSV/HSL to RGB565 unit.
// No dependencies; used by every module of the block.
package hhr_pkg;

  // Number of register stages in the datapath
  localparam int unsigned NumStages = 7;

  // Hue wrap point
  localparam logic [8:0] HueWrap = 9'd360;

  // x / 255 == (x * 0x8081) >> 23 for any 16-bit x
  localparam logic [15:0] Div255Mul = 16'h8081;
  // x / 60 == (x * 34953) >> 21 for any 15-bit x
  localparam logic [15:0] Div60Mul  = 16'd34953;

  // Channel limits before grid rounding
  localparam logic [8:0] RedBlueMax = 9'd248;
  localparam logic [8:0] GreenMax   = 9'd252;

  // 60-degree hue sectors, named by the hues at their ends
  typedef enum logic [2:0] {
    SecRedYel  = 3'd0,  // r = hi, g rises, b = lo
    SecYelGrn  = 3'd1,  // r falls, g = hi, b = lo
    SecGrnCyan = 3'd2,  // r = lo, g = hi, b rises
    SecCyanBlu = 3'd3,  // r = lo, g falls, b = hi
    SecBluMag  = 3'd4,  // r rises, g = lo, b = hi
    SecMagRed  = 3'd5   // r = hi, g = lo, b falls
  } sector_e;

  // Per-item hue information carried down the pipe
  typedef struct packed {
    sector_e    sector;
    logic [5:0] frac;    // interpolation weight, 0..60
  } hue_tag_t;

  // One load enable per register stage
  typedef logic [NumStages-1:0] stage_en_t;

endpackage

// File: src/hsv_hsl_to_rgb565_unit.sv
// HSV/HSL to RGB565 converter, top level.
// Depends on hhr_pkg, hhr_pipe_ctrl, hhr_level_path and hhr_blend_path.
//
// Usage:
//   Input channel: valid_i with hue_i (0..359, 360..511 wraps once),
//   saturation_i and level_i; an item is taken when valid_i is high and
//   stall_o is low. Output channel: valid_o with red_o, green_o, blue_o and
//   pixel_565_o; an item leaves when valid_o is high and stall_i is low.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_data_i bit 0 as the
//   colour model (0 HSV, 1 HSL); cfg_ready_o is always high. Write it only
//   while the pipe is empty.
//   An item passes from acceptance to valid_o through the seven register
//   stages (product, numerators, divide-by-255 multiply, rounding, blend
//   numerator, divide-by-60 multiply, clamp and pack). Throughput is one
//   item per cycle while the receiver does not stall.
//   Reset empties the pipe and selects HSV. When the receiver stalls, the
//   output holds and earlier stages keep filling empty slots, so items are
//   still taken until the pipe is full; then stall_o rises.
module hsv_hsl_to_rgb565_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // input items
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [8:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  level_i,
  // result items
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] pixel_565_o
);

  // Colour model register
  logic model_q, model_d;

  assign cfg_ready_o = 1'b1;
  assign model_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= 1'b0;
    end else begin
      model_q <= model_d;
    end
  end

  // Pipeline control
  hhr_pkg::stage_en_t en;

  hhr_pipe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .en_o    (en)
  );

  // Max/min front end
  logic [8:0]        hi, lo;
  hhr_pkg::hue_tag_t tag;

  hhr_level_path u_level (
    .clk_i        (clk_i),
    .en_i         (en),
    .model_i      (model_q),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .level_i      (level_i),
    .hi_o         (hi),
    .lo_o         (lo),
    .tag_o        (tag)
  );

  // Interpolation back end
  hhr_blend_path u_blend (
    .clk_i       (clk_i),
    .en_i        (en),
    .hi_i        (hi),
    .lo_i        (lo),
    .tag_i       (tag),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .pixel_565_o (pixel_565_o)
  );

endmodule

// File: src/hhr_pipe_ctrl.sv
// Valid bits and per-stage load enables for the conversion pipeline.
// Depends on hhr_pkg.
module hhr_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  output logic              valid_o,
  input  logic              stall_i,
  output hhr_pkg::stage_en_t en_o
);

  hhr_pkg::stage_en_t v_q, v_d;
  hhr_pkg::stage_en_t en;

  // A stage loads when it is empty or its content moves on; bubbles collapse
  always_comb begin
    en[hhr_pkg::NumStages-1] = !v_q[hhr_pkg::NumStages-1] || !stall_i;
    for (int k = hhr_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Valid bits follow the data
  always_comb begin
    v_d = v_q;
    if (en[0]) v_d[0] = valid_i;
    for (int k = 1; k < hhr_pkg::NumStages; k++) begin
      if (en[k]) v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign en_o    = en;
  assign stall_o = !en[0];
  assign valid_o = v_q[hhr_pkg::NumStages-1];

endmodule

// File: src/hhr_level_path.sv
// Stages 1 to 4: hue wrap and sector decode, channel max/min via divide by 255
// and rounding up to multiples of 4. Depends on hhr_pkg.
module hhr_level_path (
  input  logic               clk_i,
  input  hhr_pkg::stage_en_t en_i,
  input  logic               model_i,
  input  logic [8:0]         hue_i,
  input  logic [7:0]         saturation_i,
  input  logic [7:0]         level_i,
  output logic [8:0]         hi_o,
  output logic [8:0]         lo_o,
  output hhr_pkg::hue_tag_t  tag_o
);

  // ---- stage 1: hue wrap, level x saturation product
  logic [8:0]  hue_wrap;
  logic [7:0]  mult_sel;
  logic [15:0] s1_prod_q;
  logic [7:0]  s1_level_q;
  logic [8:0]  s1_hue_q;
  logic        s1_model_q;

  assign hue_wrap = (hue_i >= hhr_pkg::HueWrap) ? (hue_i - hhr_pkg::HueWrap) : hue_i;
  // HSL upper half spreads by (255 - l), otherwise by l
  assign mult_sel = (model_i && level_i[7]) ? (8'd255 - level_i) : level_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_prod_q  <= {8'd0, mult_sel} * {8'd0, saturation_i};
      s1_level_q <= level_i;
      s1_hue_q   <= hue_wrap;
      s1_model_q <= model_i;
    end
  end

  // ---- stage 2: numerators and sector decode
  logic [15:0]       lvl255;
  logic [15:0]       hi_num, lo_num;
  logic [8:0]        hue_diff;
  hhr_pkg::hue_tag_t tag2;
  logic [15:0]       s2_hi_num_q, s2_lo_num_q;
  hhr_pkg::hue_tag_t s2_tag_q;

  assign lvl255 = {s1_level_q, 8'd0} - {8'd0, s1_level_q};
  // HSV max is the level itself (l * 255 / 255)
  assign hi_num = lvl255 + (s1_model_q ? s1_prod_q : 16'd0);
  assign lo_num = lvl255 - s1_prod_q;

  // Sector edges belong to the lower sector
  always_comb begin
    if (s1_hue_q <= 9'd60) begin
      tag2.sector = hhr_pkg::SecRedYel;
      hue_diff    = s1_hue_q;
    end else if (s1_hue_q <= 9'd120) begin
      tag2.sector = hhr_pkg::SecYelGrn;
      hue_diff    = 9'd120 - s1_hue_q;
    end else if (s1_hue_q <= 9'd180) begin
      tag2.sector = hhr_pkg::SecGrnCyan;
      hue_diff    = s1_hue_q - 9'd120;
    end else if (s1_hue_q <= 9'd240) begin
      tag2.sector = hhr_pkg::SecCyanBlu;
      hue_diff    = 9'd240 - s1_hue_q;
    end else if (s1_hue_q <= 9'd300) begin
      tag2.sector = hhr_pkg::SecBluMag;
      hue_diff    = s1_hue_q - 9'd240;
    end else begin
      tag2.sector = hhr_pkg::SecMagRed;
      hue_diff    = 9'd360 - s1_hue_q;
    end
    tag2.frac = hue_diff[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_hi_num_q <= hi_num;
      s2_lo_num_q <= lo_num;
      s2_tag_q    <= tag2;
    end
  end

  // ---- stage 3: reciprocal multiply for divide by 255
  logic [31:0]       s3_hi_prod_q, s3_lo_prod_q;
  hhr_pkg::hue_tag_t s3_tag_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_hi_prod_q <= {16'd0, s2_hi_num_q} * {16'd0, hhr_pkg::Div255Mul};
      s3_lo_prod_q <= {16'd0, s2_lo_num_q} * {16'd0, hhr_pkg::Div255Mul};
      s3_tag_q     <= s2_tag_q;
    end
  end

  // ---- stage 4: quotient, round up to multiple of 4 (may reach 256)
  logic [8:0]        hi_up, lo_up;
  logic [8:0]        s4_hi_q, s4_lo_q;
  hhr_pkg::hue_tag_t s4_tag_q;

  assign hi_up = {1'b0, s3_hi_prod_q[30:23]} + 9'd3;
  assign lo_up = {1'b0, s3_lo_prod_q[30:23]} + 9'd3;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_hi_q  <= {hi_up[8:2], 2'b00};
      s4_lo_q  <= {lo_up[8:2], 2'b00};
      s4_tag_q <= s3_tag_q;
    end
  end

  assign hi_o  = s4_hi_q;
  assign lo_o  = s4_lo_q;
  assign tag_o = s4_tag_q;

endmodule

// File: src/hhr_blend_path.sv
// Stages 5 to 7: sector interpolation with divide by 60, clamping, grid
// rounding and 5-6-5 packing. Depends on hhr_pkg.
module hhr_blend_path (
  input  logic               clk_i,
  input  hhr_pkg::stage_en_t en_i,
  input  logic [8:0]         hi_i,
  input  logic [8:0]         lo_i,
  input  hhr_pkg::hue_tag_t  tag_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [15:0]        pixel_565_o
);

  // ---- stage 5: numerator frac * (hi - lo) + lo * 60 + 59
  logic [8:0]      diff;
  logic [14:0]     lo_x60;
  logic [14:0]     num;
  logic [14:0]     s5_num_q;
  logic [8:0]      s5_hi_q, s5_lo_q;
  hhr_pkg::sector_e s5_sec_q;

  assign diff   = hi_i - lo_i;
  assign lo_x60 = {lo_i, 6'd0} - {4'd0, lo_i, 2'd0};
  assign num    = {9'd0, tag_i.frac} * {6'd0, diff} + lo_x60 + 15'd59;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_num_q <= num;
      s5_hi_q  <= hi_i;
      s5_lo_q  <= lo_i;
      s5_sec_q <= tag_i.sector;
    end
  end

  // ---- stage 6: reciprocal multiply for divide by 60
  logic [30:0]      s6_prod_q;
  logic [8:0]       s6_hi_q, s6_lo_q;
  hhr_pkg::sector_e s6_sec_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_prod_q <= {16'd0, s5_num_q} * {15'd0, hhr_pkg::Div60Mul};
      s6_hi_q   <= s5_hi_q;
      s6_lo_q   <= s5_lo_q;
      s6_sec_q  <= s5_sec_q;
    end
  end

  // ---- stage 7: channel selection, clamp, round, pack
  function automatic logic [7:0] finish_ch(input logic [8:0] v, input logic [8:0] lim,
                                           input logic grid8);
    logic [8:0] up;
    begin
      if (v > lim) begin
        up = lim;
      end else if (grid8) begin
        up = v + 9'd7;
        up = {up[8:3], 3'b000};
      end else begin
        up = v + 9'd3;
        up = {up[8:2], 2'b00};
      end
      return up[7:0];
    end
  endfunction

  logic [8:0] mid;
  logic [8:0] r_raw, g_raw, b_raw;
  logic [7:0] r_fin, g_fin, b_fin;

  assign mid = s6_prod_q[29:21];

  always_comb begin
    unique case (s6_sec_q)
      hhr_pkg::SecRedYel:  begin r_raw = s6_hi_q; g_raw = mid;     b_raw = s6_lo_q; end
      hhr_pkg::SecYelGrn:  begin r_raw = mid;     g_raw = s6_hi_q; b_raw = s6_lo_q; end
      hhr_pkg::SecGrnCyan: begin r_raw = s6_lo_q; g_raw = s6_hi_q; b_raw = mid;     end
      hhr_pkg::SecCyanBlu: begin r_raw = s6_lo_q; g_raw = mid;     b_raw = s6_hi_q; end
      hhr_pkg::SecBluMag:  begin r_raw = mid;     g_raw = s6_lo_q; b_raw = s6_hi_q; end
      hhr_pkg::SecMagRed:  begin r_raw = s6_hi_q; g_raw = s6_lo_q; b_raw = mid;     end
      default:             begin r_raw = s6_hi_q; g_raw = s6_lo_q; b_raw = s6_lo_q; end
    endcase
  end

  assign r_fin = finish_ch(r_raw, hhr_pkg::RedBlueMax, 1'b1);
  assign g_fin = finish_ch(g_raw, hhr_pkg::GreenMax,   1'b0);
  assign b_fin = finish_ch(b_raw, hhr_pkg::RedBlueMax, 1'b1);

  logic [7:0]  red_q, green_q, blue_q;
  logic [15:0] pixel_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      red_q   <= r_fin;
      green_q <= g_fin;
      blue_q  <= b_fin;
      pixel_q <= {r_fin[7:3], g_fin[7:2], b_fin[7:3]};
    end
  end

  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign pixel_565_o = pixel_q;

endmodule

// File: src/hhr_port_checker.sv
// Port-level checks for the HSV/HSL to RGB565 unit, bound to the top level.
// Depends on hsv_hsl_to_rgb565_unit_macros.svh.
`include "hsv_hsl_to_rgb565_unit_macros.svh"

module hhr_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [15:0] pixel_565_o
);

  // Whole result payload, and the per-item consistency terms
  logic [39:0] out_bus;
  logic        pack_ok;
  logic        grid_ok;

  assign out_bus = {red_o, green_o, blue_o, pixel_565_o};
  assign pack_ok = (pixel_565_o[15:11] == red_o[7:3]) &&
                   (pixel_565_o[10:5] == green_o[7:2]) &&
                   (pixel_565_o[4:0] == blue_o[7:3]);
  assign grid_ok = (red_o[2:0] == 3'd0) && (red_o <= 8'd248) &&
                   (green_o[1:0] == 2'd0) && (green_o <= 8'd252) &&
                   (blue_o[2:0] == 3'd0) && (blue_o <= 8'd248);

  // A stalled result item holds
  `HHR_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(out_bus))

  // Packed pixel agrees with the components
  `HHR_ASSERT_NOW(a_pack, valid_o, pack_ok)

  // Components sit on their grid and under their limits
  `HHR_ASSERT_NOW(a_grid, valid_o, grid_ok)

  // An empty output slot lets every stage advance, so input is never stalled
  `HHR_ASSERT_NOW(a_no_false_stall, !valid_o, !stall_o)

endmodule

bind hsv_hsl_to_rgb565_unit hhr_port_checker u_port_checker (.*);
